FILE: rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and codes for the selective repeat reorder receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned ACK_W   = 10;
  localparam int unsigned RCNT_W  = 11;

  localparam logic REQ_META = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_REL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_CHECK,
    ST_ACK,
    ST_REL
  } srr_state_e;

  typedef struct packed {
    logic busy;
    logic clr_we;
    logic mark_we;
    logic rd_en;
    logic scan_inc;
    logic load_item;
    logic emit_ack;
    logic emit_rel;
  } srr_ctrl_t;

  typedef struct packed {
    logic go_data;
    logic clr_last;
    logic scan_more;
    logic rd_bit;
    logic run_nz;
  } srr_stat_t;

endpackage

FILE: rtl/selective_repeat_reorder_receiver.sv
// ----------------------------------------------------------------------------
// selective_repeat_reorder_receiver
// Selective repeat receiver: acknowledges chunks and releases in-order runs.
// ----------------------------------------------------------------------------
// usage:
//   an input transaction is taken when start_i is high and busy_o is low.
//   a meta item (req_type_i = 0) sets the chunk count without raising busy_o.
//   a data item marks its chunk in a bitmap RAM, then the block scans the
//   bitmap from the next expected chunk, one RAM read per pass through the
//   read and check states. a data item keeps busy_o high through the mark
//   write, the scan, the acknowledgement and, if the run is not empty, the
//   release; the scan loop over the bitmap RAM port sets how long it lasts.
//   results leave one per cycle on the result ports, each marked by a
//   one-cycle result_valid_o strobe: first the acknowledgement, then the
//   release if the run is not empty; last_o marks the final one.
//   the receiver cannot stall, so no result is ever held back.
//   after reset every bitmap entry is cleared in turn with busy_o
//   high; after the transfer completes every item is ignored.
// ----------------------------------------------------------------------------
module selective_repeat_reorder_receiver #(
  parameter int unsigned MAX_CHUNKS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         req_type_i,
  input  logic [srr_pkg::ID_W-1:0]     chunk_id_i,
  input  logic [srr_pkg::ID_W-1:0]     chunk_count_i,
  output logic                         result_valid_o,
  output logic                         result_kind_o,
  output logic [srr_pkg::ACK_W-1:0]    ack_id_o,
  output logic [srr_pkg::ACK_W-1:0]    release_start_o,
  output logic [srr_pkg::RCNT_W-1:0]   release_count_o,
  output logic                         transfer_done_o,
  output logic                         last_o
);

  import srr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CHUNKS);
  localparam int unsigned NW = $clog2(MAX_CHUNKS + 1);

  srr_ctrl_t ctrl;
  srr_stat_t stat;

  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] id_q, id_d;
  logic [NW-1:0] ne_q, ne_d;
  logic [NW-1:0] scan_q, scan_d;
  logic [NW-1:0] total_q, total_d;
  logic          fin_q, fin_d;

  logic          res_valid_q;
  logic          res_kind_q;
  logic [ACK_W-1:0]  res_ack_q;
  logic [ACK_W-1:0]  res_start_q;
  logic [RCNT_W-1:0] res_count_q;
  logic          res_done_q;
  logic          res_last_q;

  logic          accept;
  logic          id_ok;
  logic          cnt_ok;
  logic          done;
  logic [NW-1:0] run;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;

  assign accept = start_i && !ctrl.busy;
  assign id_ok  = 32'(chunk_id_i) < 32'(total_q);
  assign cnt_ok = 32'(chunk_count_i) <= 32'(MAX_CHUNKS);
  assign run    = scan_q - ne_q;
  assign done   = scan_q == total_q;

  // only looked at in idle, where busy is low
  assign stat.go_data   = start_i && (req_type_i == REQ_DATA) && !fin_q && id_ok;
  assign stat.clr_last  = clr_q == AW'(MAX_CHUNKS - 1);
  assign stat.scan_more = scan_q < total_q;
  assign stat.rd_bit    = ram_rdata;
  assign stat.run_nz    = scan_q != ne_q;

  srr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign ram_we    = ctrl.clr_we || ctrl.mark_we;
  assign ram_waddr = ctrl.clr_we ? clr_q : id_q;
  assign ram_wdata = ctrl.mark_we;

  srr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CHUNKS)
  ) u_marks (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl.rd_en),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    clr_d   = ctrl.clr_we ? clr_q + AW'(1) : clr_q;
    id_d    = id_q;
    scan_d  = scan_q;
    ne_d    = ne_q;
    total_d = total_q;
    fin_d   = fin_q;
    if (accept && (req_type_i == REQ_META) && !fin_q && cnt_ok) begin
      total_d = NW'(chunk_count_i);
    end
    if (ctrl.load_item) begin
      id_d   = chunk_id_i[AW-1:0];
      scan_d = ne_q;
    end
    if (ctrl.scan_inc) begin
      scan_d = scan_q + NW'(1);
    end
    if (ctrl.emit_rel) begin
      ne_d  = scan_q;
      fin_d = done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      id_q        <= '0;
      scan_q      <= '0;
      ne_q        <= '0;
      total_q     <= '0;
      fin_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      id_q        <= id_d;
      scan_q      <= scan_d;
      ne_q        <= ne_d;
      total_q     <= total_d;
      fin_q       <= fin_d;
      res_valid_q <= ctrl.emit_ack || ctrl.emit_rel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit_ack) begin
      res_kind_q  <= KIND_ACK;
      res_ack_q   <= ACK_W'(id_q);
      res_start_q <= '0;
      res_count_q <= '0;
      res_done_q  <= 1'b0;
      res_last_q  <= !stat.run_nz;
    end else if (ctrl.emit_rel) begin
      res_kind_q  <= KIND_REL;
      res_ack_q   <= '0;
      res_start_q <= ACK_W'(ne_q);
      res_count_q <= RCNT_W'(run);
      res_done_q  <= done;
      res_last_q  <= 1'b1;
    end
  end

  assign busy_o          = ctrl.busy;
  assign result_valid_o  = res_valid_q;
  assign result_kind_o   = res_kind_q;
  assign ack_id_o        = res_ack_q;
  assign release_start_o = res_start_q;
  assign release_count_o = res_count_q;
  assign transfer_done_o = res_done_q;
  assign last_o          = res_last_q;

endmodule

FILE: rtl/srr_ram.sv
// ----------------------------------------------------------------------------
// srr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module srr_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/srr_seq.sv
// ----------------------------------------------------------------------------
// srr_seq
// Sequencer: clearing pass, mark write, bitmap scan and result emission.
// ----------------------------------------------------------------------------
module srr_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srr_pkg::srr_stat_t stat_i,
  output srr_pkg::srr_ctrl_t ctrl_o
);

  import srr_pkg::*;

  srr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (stat_i.go_data) state_d = ST_WRITE;
      end
      ST_WRITE: state_d = ST_READ;
      ST_READ: begin
        state_d = stat_i.scan_more ? ST_CHECK : ST_ACK;
      end
      ST_CHECK: begin
        state_d = stat_i.rd_bit ? ST_READ : ST_ACK;
      end
      ST_ACK: begin
        state_d = stat_i.run_nz ? ST_REL : ST_IDLE;
      end
      ST_REL: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ctrl_o.busy   = 1'b1;
        ctrl_o.clr_we = 1'b1;
      end
      ST_IDLE: begin
        ctrl_o.load_item = stat_i.go_data;
      end
      ST_WRITE: begin
        ctrl_o.busy    = 1'b1;
        ctrl_o.mark_we = 1'b1;
      end
      ST_READ: begin
        ctrl_o.busy  = 1'b1;
        ctrl_o.rd_en = stat_i.scan_more;
      end
      ST_CHECK: begin
        ctrl_o.busy     = 1'b1;
        ctrl_o.scan_inc = stat_i.rd_bit;
      end
      ST_ACK: begin
        ctrl_o.busy     = 1'b1;
        ctrl_o.emit_ack = 1'b1;
      end
      ST_REL: begin
        ctrl_o.busy     = 1'b1;
        ctrl_o.emit_rel = 1'b1;
      end
      default: ctrl_o = '0;
    endcase
  end

endmodule
